[rtl/ptc_pkg.sv]
package ptc_pkg;

    localparam int GROUP_SAMPLES = 7;
    localparam int MAX_TAPS      = 128;
    localparam int TAP_IDX_W     = 7;
    localparam int TERN_W        = 2;
    localparam int ACC_W         = 9;
    localparam int SLOT_W        = 3;

    localparam int WIN_LEN   = MAX_TAPS + GROUP_SAMPLES - 1;
    localparam int KERN_ROWS = (MAX_TAPS + GROUP_SAMPLES - 1) / GROUP_SAMPLES;
    localparam int WIN_ROWS  = (WIN_LEN + GROUP_SAMPLES - 1) / GROUP_SAMPLES;
    localparam int KROW_W    = (KERN_ROWS > 1) ? $clog2(KERN_ROWS) : 1;
    localparam int WROW_W    = (WIN_ROWS > 1) ? $clog2(WIN_ROWS) : 1;
    localparam int LANE_W    = (GROUP_SAMPLES > 1) ? $clog2(GROUP_SAMPLES) : 1;
    localparam int DELTA_W   = $clog2(GROUP_SAMPLES + 1) + 1;

    localparam int RECIP_SH = 12;
    localparam int RECIP    = (2 ** RECIP_SH) / GROUP_SAMPLES;
    localparam int SPLIT_W  = TAP_IDX_W + RECIP_SH;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_GROUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef logic signed [TERN_W-1:0] tern_t;
    typedef tern_t [GROUP_SAMPLES-1:0] tern_row_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef acc_t [GROUP_SAMPLES-1:0] acc_row_t;

    typedef struct packed {
        logic [KROW_W-1:0] row;
        logic [LANE_W-1:0] lane;
    } tap_pos_t;

    typedef struct packed {
        logic              wr_en;
        logic [KROW_W-1:0] wr_row;
        logic [LANE_W-1:0] wr_lane;
        tern_t             wr_tap;
        logic              rd_en;
        logic [WROW_W-1:0] rd_row;
    } kern_req_t;

    // The code for minus two saturates to minus one.
    function automatic tern_t to_tern(input logic [1:0] code);
        tern_t t;
        unique case (code)
            2'b00:   t = 2'sd0;
            2'b01:   t = 2'sd1;
            default: t = -2'sd1;
        endcase
        return t;
    endfunction

    // Row and lane of a tap by a reciprocal multiply and one correction step.
    function automatic tap_pos_t tap_split(input logic [TAP_IDX_W-1:0] idx);
        logic [SPLIT_W-1:0]   prod;
        logic [TAP_IDX_W-1:0] q;
        logic [TAP_IDX_W-1:0] rem;
        tap_pos_t             pos;
        prod = SPLIT_W'(idx) * SPLIT_W'(RECIP);
        q    = TAP_IDX_W'(prod >> RECIP_SH);
        rem  = idx - TAP_IDX_W'(int'(q) * GROUP_SAMPLES);
        if (rem >= TAP_IDX_W'(GROUP_SAMPLES))
        begin
            q   = q + 1'b1;
            rem = rem - TAP_IDX_W'(GROUP_SAMPLES);
        end
        pos.row  = KROW_W'(q);
        pos.lane = LANE_W'(rem);
        return pos;
    endfunction

endpackage

[rtl/ptc_if.sv]
interface ptc_item_if import ptc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           cmd;
    logic [TAP_IDX_W-1:0] tap_index;
    tern_t                tap_value;
    tern_t                sample_0;
    tern_t                sample_1;
    tern_t                sample_2;
    tern_t                sample_3;
    tern_t                sample_4;
    tern_t                sample_5;
    tern_t                sample_6;

    modport source (
        output valid, cmd, tap_index, tap_value,
        output sample_0, sample_1, sample_2, sample_3, sample_4, sample_5, sample_6,
        input  ready
    );
    modport sink (
        input  valid, cmd, tap_index, tap_value,
        input  sample_0, sample_1, sample_2, sample_3, sample_4, sample_5, sample_6,
        output ready
    );
endinterface

interface ptc_out_if import ptc_pkg::*; ();
    logic              valid;
    logic              ready;
    acc_t              conv_value;
    logic [SLOT_W-1:0] slot;
    logic              last;

    modport source (output valid, conv_value, slot, last, input ready);
    modport sink (input valid, conv_value, slot, last, output ready);
endinterface

[rtl/ptc_kernel_store.sv]
module ptc_kernel_store import ptc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  kern_req_t req,
    output tern_row_t prev_row,
    output tern_row_t cur_row
);

    tern_row_t              mem [KERN_ROWS];
    logic [KERN_ROWS-1:0]   row_vld_reg;
    tern_row_t              prev_reg;
    tern_row_t              cur_reg;
    logic [KROW_W-1:0]      prev_idx;
    logic [KROW_W-1:0]      cur_idx;
    logic                   prev_ok;
    logic                   cur_ok;

    always_comb
    begin
        cur_idx  = KROW_W'(req.rd_row);
        prev_idx = KROW_W'(req.rd_row - 1'b1);
        cur_ok   = int'(req.rd_row) < KERN_ROWS;
        prev_ok  = (req.rd_row != '0) && (int'(req.rd_row) <= KERN_ROWS);
    end

    // A row that was never written reads as zero taps.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            for (int l = 0; l < GROUP_SAMPLES; l++)
            begin
                if (LANE_W'(l) == req.wr_lane)
                    mem[req.wr_row][l] <= req.wr_tap;
                else if (!row_vld_reg[req.wr_row])
                    mem[req.wr_row][l] <= '0;
            end
        end
        if (req.rd_en)
        begin
            if (prev_ok && row_vld_reg[prev_idx])
                prev_reg <= mem[prev_idx];
            else
                prev_reg <= '0;
            if (cur_ok && row_vld_reg[cur_idx])
                cur_reg <= mem[cur_idx];
            else
                cur_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_vld_reg <= '0;
        else if (req.wr_en)
            row_vld_reg[req.wr_row] <= 1'b1;
    end

    assign prev_row = prev_reg;
    assign cur_row  = cur_reg;

endmodule

[rtl/ptc_lane.sv]
module ptc_lane import ptc_pkg::*;
(
    input  tern_row_t samples,
    input  tern_row_t taps,
    input  acc_t      acc_in,
    input  logic      acc_ok,
    output acc_t      acc_out
);

    logic signed [DELTA_W-1:0] delta;

    always_comb
    begin
        delta = '0;
        for (int i = 0; i < GROUP_SAMPLES; i++)
            delta = delta + DELTA_W'(samples[i] * taps[i]);
        acc_out = (acc_ok ? acc_in : '0) + ACC_W'(delta);
    end

endmodule

[rtl/ptc_merge.sv]
module ptc_merge import ptc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  acc_row_t  vals,
    output logic      idle,
    ptc_out_if.source result
);

    acc_row_t          vals_reg;
    logic              busy_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              last_slot;

    assign last_slot = slot_reg == SLOT_W'(GROUP_SAMPLES - 1);

    always_ff @(posedge clk)
    begin
        if (load)
            vals_reg <= vals;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            slot_reg <= '0;
        end
        else if (busy_reg && result.ready)
        begin
            busy_reg <= !last_slot;
            slot_reg <= last_slot ? '0 : slot_reg + 1'b1;
        end
    end

    assign idle              = !busy_reg;
    assign result.valid      = busy_reg;
    assign result.conv_value = vals_reg[slot_reg[LANE_W-1:0]];
    assign result.slot       = slot_reg;
    assign result.last       = last_slot;

endmodule

[rtl/packed_ternary_convolution.sv]
// Channel  Direction  Word
// item     in         cmd, tap_index, tap_value, sample_0 .. sample_6
// result   out        conv_value, slot, last
//
// A sample group is one pass over the window; the window memory has one read and one
// write port, so the seven lanes update one window row of seven entries per cycle
// over 20 rows; the last row of a pass waits until earlier outputs have all left.
// The seven finished outputs leave one per cycle from a register bank unless stalled.
// Reset clears the kernel and window row valid bits at once; there is no sweep.
// A stalled result holds only the last row pass of the following group.
module packed_ternary_convolution import ptc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ptc_item_if.sink  item,
    ptc_out_if.source result
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

    state_t                 state_reg;
    logic [WROW_W-1:0]      step_reg;
    logic [WROW_W-1:0]      base_reg;
    tern_row_t              samp_reg;
    logic [WIN_ROWS-1:0]    win_vld_reg;
    logic                   b_vld_reg;
    logic [WROW_W-1:0]      b_step_reg;
    logic [WROW_W-1:0]      b_phys_reg;

    acc_row_t               win_mem [WIN_ROWS];
    acc_row_t               win_rd_reg;
    logic                   win_rdv_reg;

    logic                   item_acc;
    logic                   issue;
    logic                   merge_idle;
    logic [WROW_W:0]        phys_sum;
    logic [WROW_W-1:0]      rd_phys;
    tap_pos_t               tap_pos;
    kern_req_t              kreq;
    tern_row_t              kprev;
    tern_row_t              kcur;
    tern_t [2*GROUP_SAMPLES-1:0] taps_all;
    acc_row_t               lane_sum;
    tern_row_t              samp_in;

    assign item.ready = state_reg == ST_IDLE;
    assign item_acc   = item.valid && item.ready;
    assign issue      = (state_reg == ST_RUN) && ((step_reg != '0) || merge_idle);

    always_comb
    begin
        phys_sum = {1'b0, base_reg} + {1'b0, step_reg};
        if (phys_sum >= (WROW_W + 1)'(WIN_ROWS))
            rd_phys = WROW_W'(phys_sum - (WROW_W + 1)'(WIN_ROWS));
        else
            rd_phys = WROW_W'(phys_sum);
    end

    always_comb
    begin
        tap_pos      = tap_split(item.tap_index);
        kreq.wr_en   = item_acc && (item.cmd == CMD_LOAD) && (int'(item.tap_index) < MAX_TAPS);
        kreq.wr_row  = tap_pos.row;
        kreq.wr_lane = tap_pos.lane;
        kreq.wr_tap  = to_tern(item.tap_value);
        kreq.rd_en   = issue;
        kreq.rd_row  = step_reg;
    end

    always_comb
    begin
        samp_in[0] = to_tern(item.sample_0);
        samp_in[1] = to_tern(item.sample_1);
        samp_in[2] = to_tern(item.sample_2);
        samp_in[3] = to_tern(item.sample_3);
        samp_in[4] = to_tern(item.sample_4);
        samp_in[5] = to_tern(item.sample_5);
        samp_in[6] = to_tern(item.sample_6);
    end

    ptc_kernel_store u_kernel
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (kreq),
        .prev_row (kprev),
        .cur_row  (kcur)
    );

    assign taps_all = {kcur, kprev};

    // Output position l of a row pairs sample i with the tap l - i places along.
    for (genvar l = 0; l < GROUP_SAMPLES; l++)
    begin : g_lane
        tern_row_t lane_taps;

        always_comb
        begin
            for (int i = 0; i < GROUP_SAMPLES; i++)
                lane_taps[i] = taps_all[GROUP_SAMPLES + l - i];
        end

        ptc_lane u_lane
        (
            .samples (samp_reg),
            .taps    (lane_taps),
            .acc_in  (win_rd_reg[l]),
            .acc_ok  (win_rdv_reg),
            .acc_out (lane_sum[l])
        );
    end

    ptc_merge u_merge
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (b_vld_reg && (b_step_reg == '0)),
        .vals   (lane_sum),
        .idle   (merge_idle),
        .result (result)
    );

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            win_rd_reg  <= win_mem[rd_phys];
            win_rdv_reg <= win_vld_reg[rd_phys];
        end
        if (b_vld_reg && (b_step_reg != '0))
            win_mem[b_phys_reg] <= lane_sum;
    end

    // Row zero of the window is finished last; its slot becomes the new last row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            base_reg    <= '0;
            samp_reg    <= '0;
            win_vld_reg <= '0;
            b_vld_reg   <= 1'b0;
            b_step_reg  <= '0;
            b_phys_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_acc)
                    begin
                        unique case (item.cmd)
                            CMD_GROUP:
                            begin
                                samp_reg  <= samp_in;
                                step_reg  <= WROW_W'(1);
                                state_reg <= ST_RUN;
                            end
                            CMD_CLEAR:
                                win_vld_reg <= '0;
                            default:
                                ;
                        endcase
                    end
                end
                ST_RUN:
                begin
                    if (issue)
                    begin
                        if (step_reg == WROW_W'(WIN_ROWS - 1))
                            step_reg <= '0;
                        else
                            step_reg <= step_reg + 1'b1;
                        if (step_reg == '0)
                            state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                    state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase

            b_vld_reg <= issue;
            if (issue)
            begin
                b_step_reg <= step_reg;
                b_phys_reg <= rd_phys;
            end

            if (b_vld_reg)
            begin
                if (b_step_reg == '0)
                begin
                    win_vld_reg[b_phys_reg] <= 1'b0;
                    if (base_reg == WROW_W'(WIN_ROWS - 1))
                        base_reg <= '0;
                    else
                        base_reg <= base_reg + 1'b1;
                end
                else
                begin
                    win_vld_reg[b_phys_reg] <= 1'b1;
                end
            end
        end
    end

    a_win_ports: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && b_vld_reg) |-> (rd_phys != b_phys_reg))
        else $error("window read and write hit the same row");

    a_merge_free: assert property (@(posedge clk) disable iff (!rst_n)
        (b_vld_reg && (b_step_reg == '0)) |-> merge_idle)
        else $error("finished row loaded while outputs still pending");

    a_base_move: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(base_reg) |-> $past(b_vld_reg && (b_step_reg == '0)))
        else $error("window base moved outside the end of a group");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ptc_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam logic [1:0] CODE_ZERO = 2'b00;
    localparam logic [1:0] CODE_PLUS = 2'b01;
    localparam logic [1:0] CODE_MINUS_TWO = 2'b10;
    localparam logic [1:0] CODE_MINUS = 2'b11;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_WORDS = 400;
    localparam int DRAIN_GROUPS = 20;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [TAP_IDX_W-1:0] tap_index;
        tern_t                tap_value;
        tern_row_t            samples;
    } in_word_t;

    typedef struct packed {
        acc_t              conv_value;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } out_word_t;

    // Keeps its own kernel and overlap-add window and queues the outputs that each
    // sample group must produce.
    class conv_tracker;
        int        kern[MAX_TAPS];
        acc_t      win[WIN_LEN];
        out_word_t pending[$];
        int        errors;

        function new();
            foreach (kern[k])
            begin
                kern[k] = 0;
            end
            foreach (win[j])
            begin
                win[j] = '0;
            end
            errors = 0;
        endfunction

        function int level_of(input logic [1:0] code);
            if (code == CODE_ZERO)
            begin
                return 0;
            end
            if (code == CODE_PLUS)
            begin
                return 1;
            end
            return -1;
        endfunction

        function void take_word(input in_word_t w);
            int        s;
            out_word_t o;
            case (w.cmd)
                CMD_LOAD:
                begin
                    if (int'(w.tap_index) < MAX_TAPS)
                    begin
                        kern[w.tap_index] = level_of(w.tap_value);
                    end
                end
                CMD_CLEAR:
                begin
                    foreach (win[j])
                    begin
                        win[j] = '0;
                    end
                end
                CMD_GROUP:
                begin
                    for (int i = 0; i < GROUP_SAMPLES; i++)
                    begin
                        s = level_of(w.samples[i]);
                        if (s != 0)
                        begin
                            for (int k = 0; k < MAX_TAPS; k++)
                            begin
                                win[i + k] = win[i + k] + acc_t'(s * kern[k]);
                            end
                        end
                    end
                    for (int i = 0; i < GROUP_SAMPLES; i++)
                    begin
                        o.conv_value = win[i];
                        o.slot = SLOT_W'(i);
                        o.last = (i == GROUP_SAMPLES - 1);
                        pending.insert(pending.size(), o);
                    end
                    for (int j = 0; j < WIN_LEN; j++)
                    begin
                        win[j] = (j < WIN_LEN - GROUP_SAMPLES) ? win[j + GROUP_SAMPLES] : '0;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_output(input out_word_t got);
            out_word_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result: conv_value %0d slot %0d last %0d",
                       got.conv_value, got.slot, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.conv_value !== want.conv_value)
            begin
                $error("conv_value: expected %0d, got %0d", want.conv_value, got.conv_value);
                errors++;
            end
            if (got.slot !== want.slot)
            begin
                $error("slot: expected %0d, got %0d", want.slot, got.slot);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic steady = 1'b0;
    int   words_sent = 0;
    int   quiet_cycles = 0;

    conv_tracker tracker;
    in_word_t    seen_word;
    out_word_t   seen_out;

    ptc_item_if item_bus();
    ptc_out_if  result_bus();

    packed_ternary_convolution dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic in_word_t tap_word(input int idx, input logic [1:0] code);
        in_word_t w;
        w = '0;
        w.cmd = CMD_LOAD;
        w.tap_index = TAP_IDX_W'(idx);
        w.tap_value = code;
        w.samples = tern_row_t'($urandom());
        return w;
    endfunction

    function automatic in_word_t clear_word();
        in_word_t w;
        w = in_word_t'({$urandom(), $urandom()});
        w.cmd = CMD_CLEAR;
        return w;
    endfunction

    function automatic in_word_t group_word(input tern_row_t row);
        in_word_t w;
        w.cmd = CMD_GROUP;
        w.tap_index = TAP_IDX_W'($urandom());
        w.tap_value = tern_t'($urandom());
        w.samples = row;
        return w;
    endfunction

    function automatic tern_row_t fill_row(input logic [1:0] code);
        tern_row_t row;
        for (int i = 0; i < GROUP_SAMPLES; i++)
        begin
            row[i] = code;
        end
        return row;
    endfunction

    // Content styles: fully random, all plus one, all minus one in either code,
    // all zero, or mostly zero.
    function automatic tern_row_t random_row(input int style);
        tern_row_t row;
        for (int i = 0; i < GROUP_SAMPLES; i++)
        begin
            case (style)
                1: row[i] = CODE_PLUS;
                2: row[i] = $urandom_range(0, 1) ? CODE_MINUS : CODE_MINUS_TWO;
                3: row[i] = CODE_ZERO;
                4: row[i] = ($urandom_range(0, 4) == 0) ? tern_t'($urandom()) : CODE_ZERO;
                default: row[i] = tern_t'($urandom());
            endcase
        end
        return row;
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            item_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_bus.cmd = w.cmd;
        item_bus.tap_index = w.tap_index;
        item_bus.tap_value = w.tap_value;
        item_bus.sample_0 = w.samples[0];
        item_bus.sample_1 = w.samples[1];
        item_bus.sample_2 = w.samples[2];
        item_bus.sample_3 = w.samples[3];
        item_bus.sample_4 = w.samples[4];
        item_bus.sample_5 = w.samples[5];
        item_bus.sample_6 = w.samples[6];
        item_bus.valid = 1'b1;
        @(posedge clk);
        while (!item_bus.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (w.cmd != CMD_NOP)
        begin
            words_sent++;
        end
    endtask

    task automatic send_drain();
        for (int g = 0; g < DRAIN_GROUPS; g++)
        begin
            send_word(group_word(fill_row(CODE_ZERO)));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                seen_out.conv_value = result_bus.conv_value;
                seen_out.slot = result_bus.slot;
                seen_out.last = result_bus.last;
                tracker.check_output(seen_out);
            end
            if (item_bus.valid && item_bus.ready)
            begin
                seen_word.cmd = item_bus.cmd;
                seen_word.tap_index = item_bus.tap_index;
                seen_word.tap_value = item_bus.tap_value;
                seen_word.samples = {item_bus.sample_6, item_bus.sample_5, item_bus.sample_4,
                                     item_bus.sample_3, item_bus.sample_2, item_bus.sample_1,
                                     item_bus.sample_0};
                tracker.take_word(seen_word);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int stall;
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 19);
            if (stall != 0)
            begin
                result_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_bus.ready = 1'b1;
            @(posedge clk);
            while (!result_bus.valid)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    initial
    begin
        int        target;
        int        style;
        int        count;
        bit        first;
        logic [1:0] code;
        in_word_t  noise;
        tracker = new();
        item_bus.valid = 1'b0;
        item_bus.cmd = CMD_LOAD;
        item_bus.tap_index = '0;
        item_bus.tap_value = '0;
        item_bus.sample_0 = '0;
        item_bus.sample_1 = '0;
        item_bus.sample_2 = '0;
        item_bus.sample_3 = '0;
        item_bus.sample_4 = '0;
        item_bus.sample_5 = '0;
        item_bus.sample_6 = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(tap_word(0, CODE_PLUS));
        send_word(tap_word(MAX_TAPS - 1, CODE_MINUS));
        send_word(tap_word(1, CODE_MINUS_TWO));
        send_word(tap_word(64, CODE_PLUS));
        send_word(tap_word(3, CODE_ZERO));
        noise = clear_word();
        noise.cmd = CMD_NOP;
        send_word(noise);
        send_word(group_word(fill_row(CODE_PLUS)));
        send_word(group_word(fill_row(CODE_MINUS_TWO)));
        send_word(group_word(fill_row(CODE_MINUS)));
        send_word(group_word({CODE_MINUS, CODE_ZERO, CODE_PLUS, CODE_ZERO,
                              CODE_MINUS, CODE_MINUS_TWO, CODE_PLUS}));
        send_word(group_word(fill_row(CODE_ZERO)));
        send_word(clear_word());
        send_word(group_word({CODE_PLUS, CODE_ZERO, CODE_ZERO, CODE_ZERO,
                              CODE_ZERO, CODE_ZERO, CODE_ZERO}));
        for (int g = 0; g < 12; g++)
        begin
            send_word(group_word(fill_row(CODE_ZERO)));
        end

        target = words_sent + RANDOM_WORDS;
        first = 1'b1;
        while (words_sent < target)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if (first || $urandom_range(0, 9) == 0)
            begin
                code = first ? CODE_PLUS : 2'($urandom());
                style = first ? 0 : $urandom_range(0, 1);
                for (int k = 0; k < MAX_TAPS; k++)
                begin
                    send_word(tap_word(k, (style == 0) ? code : 2'($urandom())));
                end
            end
            else
            begin
                count = $urandom_range(0, 12);
                for (int n = 0; n < count; n++)
                begin
                    send_word(tap_word($urandom_range(0, MAX_TAPS - 1), 2'($urandom())));
                end
            end
            if ($urandom_range(0, 1) == 1)
            begin
                send_word(clear_word());
            end
            if ($urandom_range(0, 4) == 0)
            begin
                noise = in_word_t'({$urandom(), $urandom()});
                noise.cmd = CMD_NOP;
                send_word(noise);
            end
            count = $urandom_range(1, 25);
            for (int g = 0; g < count; g++)
            begin
                style = first ? 1 : $urandom_range(0, 4);
                send_word(group_word(random_row(style)));
            end
            if (first || $urandom_range(0, 2) == 0)
            begin
                send_drain();
            end
            first = 1'b0;
        end
        item_bus.valid = 1'b0;

        while (tracker.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (tracker.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[packed_ternary_convolution.f]
rtl/ptc_pkg.sv
rtl/ptc_if.sv
rtl/ptc_kernel_store.sv
rtl/ptc_lane.sv
rtl/ptc_merge.sv
rtl/packed_ternary_convolution.sv
tb/sv/tb_top.sv
